// ===== src/rational_arithmetic_unit_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_ASSERT_SVH

// General clocked property with reset disable.
`define RAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication.
`define RAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 32;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_EQ  = 3'd4,
    ACT_GT  = 3'd5,
    ACT_LT  = 3'd6,
    ACT_NOP = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FORM,
    ST_GCD,
    ST_GSHIFT,
    ST_DIVN,
    ST_DIVD,
    ST_FIN
  } state_t;

endpackage

// ===== src/rational_arithmetic_unit_core.sv =====
// Each accepted word runs through the four multiply steps and the form step; compares and zero
// denominators then go straight to the output, other actions first run the binary GCD, the
// shift back by the common factors of two and the two divisions by the GCD.
// The shared units hold one item, so a new word is taken only once the last one is done.
// A finished result waits in the output register while the next word is taken.
// Synchronous active-high reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Fraction add, subtract, multiply, divide and compare with GCD reduction.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // a_num, a_den, b_num, b_den from bit 0 up, zero padded
  input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] s_tdata,
  // action
  input  logic [2:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // res_num, res_den from bit 0 up, zero padded
  output logic [71:0]                         m_tdata,
  // status
  output logic                                m_tuser
);

  localparam int OW   = OPERAND_WIDTH;
  localparam int XW   = OW + 1;
  localparam int NW   = 2 * XW;
  localparam int KW   = $clog2(NW + 1);
  localparam int NUMW = rau_pkg::RES_NUM_W;
  localparam int DENW = rau_pkg::RES_DEN_W;

  rau_pkg::state_t state, state_next;

  logic [2:0]           act;
  logic signed [XW-1:0] an, ad, bn, bd;
  logic [1:0]           mcnt;
  logic signed [NW-1:0] prod [4];
  logic signed [XW-1:0] mul_a, mul_b;
  logic signed [NW-1:0] mul_p;
  logic signed [NW-1:0] sum, dif, fn, fd;
  logic [NW-1:0]        mn, md, gx, gy, qn;
  logic [KW-1:0]        k;
  logic                 neg;
  logic [NUMW-1:0]      rnum;
  logic [DENW-1:0]      rden;
  logic                 rstat;
  logic [NUMW-1:0]      out_num;
  logic [DENW-1:0]      out_den;
  logic                 out_st;
  logic                 div_start, div_done;
  logic [NW-1:0]        div_dividend, div_quot;
  logic                 gcd_end, cmp_act, out_free;
  logic signed [NW-1:0] sq;
  logic signed [XW-1:0] in_an, in_ad, in_bn, in_bd;

  assign s_tready = (state == rau_pkg::ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {7'd0, out_den, out_num};
  assign m_tuser  = out_st;

  assign in_an = XW'(signed'(s_tdata[OW-1:0]));
  assign in_ad = XW'(signed'(s_tdata[2*OW-1:OW]));
  assign in_bn = XW'(signed'(s_tdata[3*OW-1:2*OW]));
  assign in_bd = XW'(signed'(s_tdata[4*OW-1:3*OW]));

  // The one multiplier steps through the four cross products.
  always_comb begin
    unique case (mcnt)
      2'd0: begin mul_a = an; mul_b = bd; end
      2'd1: begin mul_a = ad; mul_b = bn; end
      2'd2: begin mul_a = an; mul_b = bn; end
      default: begin mul_a = ad; mul_b = bd; end
    endcase
  end
  assign mul_p = NW'(mul_a) * NW'(mul_b);

  assign sum = prod[0] + prod[1];
  assign dif = prod[0] - prod[1];
  assign cmp_act = (act == rau_pkg::ACT_EQ) || (act == rau_pkg::ACT_GT) ||
                   (act == rau_pkg::ACT_LT) || (act == rau_pkg::ACT_NOP);

  always_comb begin
    fn = prod[2];
    fd = prod[3];
    unique case (act)
      rau_pkg::ACT_ADD: begin fn = sum;     fd = prod[3]; end
      rau_pkg::ACT_SUB: begin fn = dif;     fd = prod[3]; end
      rau_pkg::ACT_MUL: begin fn = prod[2]; fd = prod[3]; end
      rau_pkg::ACT_DIV: begin fn = prod[0]; fd = prod[1]; end
      default: begin fn = prod[2]; fd = prod[3]; end
    endcase
  end

  assign gcd_end      = (gx == '0) || (gy == '0);
  assign div_start    = ((state == rau_pkg::ST_GSHIFT) && (k == '0)) ||
                        ((state == rau_pkg::ST_DIVN) && div_done);
  assign div_dividend = (state == rau_pkg::ST_GSHIFT) ? mn : md;
  assign sq = neg ? -signed'(qn) : signed'(qn);

  rau_divider #(.NW(NW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (gx),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= rau_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rau_pkg::ST_IDLE:   if (s_tvalid) state_next = rau_pkg::ST_MUL;
      rau_pkg::ST_MUL:    if (mcnt == 2'd3) state_next = rau_pkg::ST_FORM;
      rau_pkg::ST_FORM: begin
        if (cmp_act || fd == '0) state_next = rau_pkg::ST_FIN;
        else                     state_next = rau_pkg::ST_GCD;
      end
      rau_pkg::ST_GCD:    if (gcd_end) state_next = rau_pkg::ST_GSHIFT;
      rau_pkg::ST_GSHIFT: if (k == '0) state_next = rau_pkg::ST_DIVN;
      rau_pkg::ST_DIVN:   if (div_done) state_next = rau_pkg::ST_DIVD;
      rau_pkg::ST_DIVD:   if (div_done) state_next = rau_pkg::ST_FIN;
      rau_pkg::ST_FIN:    if (out_free) state_next = rau_pkg::ST_IDLE;
      default:            state_next = rau_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      mcnt     <= '0;
    end else begin
      if (state == rau_pkg::ST_FIN && out_free) m_tvalid <= 1'b1;
      else if (m_tready)                         m_tvalid <= 1'b0;
      unique case (state)
        rau_pkg::ST_IDLE: mcnt <= '0;
        rau_pkg::ST_MUL:  mcnt <= mcnt + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      rau_pkg::ST_IDLE: begin
        act <= s_tuser;
        // Compares work on positive denominators.
        if (s_tuser >= rau_pkg::ACT_EQ && in_ad < 0) begin
          an <= -in_an;
          ad <= -in_ad;
        end else begin
          an <= in_an;
          ad <= in_ad;
        end
        if (s_tuser >= rau_pkg::ACT_EQ && in_bd < 0) begin
          bn <= -in_bn;
          bd <= -in_bd;
        end else begin
          bn <= in_bn;
          bd <= in_bd;
        end
      end
      rau_pkg::ST_MUL: prod[mcnt] <= mul_p;
      rau_pkg::ST_FORM: begin
        rden  <= DENW'(1);
        rstat <= 1'b0;
        if (cmp_act) begin
          priority case (act)
            rau_pkg::ACT_EQ: rnum <= NUMW'(dif == '0);
            rau_pkg::ACT_GT: rnum <= NUMW'(dif > 0);
            rau_pkg::ACT_LT: rnum <= NUMW'(dif < 0);
            default:         rnum <= '0;
          endcase
        end else if (fd == '0) begin
          rnum  <= '0;
          rden  <= '0;
          rstat <= 1'b1;
        end
        mn  <= fn[NW-1] ? NW'(-fn) : NW'(fn);
        md  <= fd[NW-1] ? NW'(-fd) : NW'(fd);
        gx  <= fn[NW-1] ? NW'(-fn) : NW'(fn);
        gy  <= fd[NW-1] ? NW'(-fd) : NW'(fd);
        neg <= fn[NW-1] ^ fd[NW-1];
        k   <= '0;
      end
      rau_pkg::ST_GCD: begin
        // Binary GCD: one shift or one subtract per cycle.
        priority if (gcd_end) begin
          if (gx == '0) gx <= gy;
        end else if (!gx[0] && !gy[0]) begin
          gx <= gx >> 1;
          gy <= gy >> 1;
          k  <= k + 1'b1;
        end else if (!gx[0]) begin
          gx <= gx >> 1;
        end else if (!gy[0]) begin
          gy <= gy >> 1;
        end else if (gx <= gy) begin
          gy <= gy - gx;
        end else begin
          gx <= gx - gy;
        end
      end
      rau_pkg::ST_GSHIFT: begin
        if (k != '0) begin
          gx <= gx << 1;
          k  <= k - 1'b1;
        end
      end
      rau_pkg::ST_DIVN: if (div_done) qn <= div_quot;
      rau_pkg::ST_DIVD: begin
        if (div_done) begin
          rnum <= NUMW'(sq);
          rden <= DENW'(div_quot);
        end
      end
      rau_pkg::ST_FIN: begin
        if (out_free) begin
          out_num <= rnum;
          out_den <= rden;
          out_st  <= rstat;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/rau_divider.sv =====
// ----------------------------------------------------------------------------
// rau_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_divider #(
  parameter int NW = 34
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q;
  logic [NW:0]   r;
  logic [NW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [NW:0]   r_shift;
  logic [NW:0]   diff;

  assign r_shift  = {r[NW-1:0], q[NW-1]};
  assign diff     = r_shift - {1'b0, dvs};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      r   <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[NW]) begin
        r <= diff;
        q <= {q[NW-2:0], 1'b1};
      end else begin
        r <= r_shift;
        q <= {q[NW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== src/rau_checker.sv =====
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks of the rational arithmetic unit.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_core_assert.svh"

module rau_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic        m_tuser
);

  `RAU_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "ready after accept")
  `RAU_ASSERT(a_hold_stall, (m_tvalid && !m_tready) |=> $stable(m_tdata), "stalled word moved")
  `RAU_ASSERT_IMP(a_err_zero, m_tvalid && m_tuser, m_tdata[64:0] == 65'd0, "error not 0/0")
  `RAU_ASSERT_IMP(a_ok_den, m_tvalid && !m_tuser, m_tdata[64:33] != 32'd0, "zero denominator")

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
